[rtl/assert_macros.svh]
// Assertion macros shared by the tessellator RTL.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/cbt_pkg.sv]
// Package for the cubic B-spline tessellator: widths, constants, FSM and status types.
// Used by cbt_div and cubic_bspline_tessellator_top; depends on nothing.
package cbt_pkg;

    localparam int COORD_W     = 16;
    localparam int STEP_W      = 6;
    localparam int WIN_DEPTH   = 3;
    localparam int DEN_W       = 21;  // 6*n^3 for n up to 63
    localparam int ACC_W       = 40;
    localparam int DIVD_W      = 39;  // 2*acc + den
    localparam int DIVS_W      = 22;  // 2*den
    localparam int QUO_W       = 16;
    localparam int CNT_W       = 4;   // log2 of QUO_W
    localparam int MUL_A_W     = 22;
    localparam int MUL_B_W     = 17;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;

    localparam logic [STEP_W-1:0] STEPS_RESET = 6'd16;
    localparam logic [1:0]        WIN_FULL    = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NSQ,
        S_NCUBE,
        S_KSQ,
        S_KCUBE,
        S_MSQ,
        S_MCUBE,
        S_K2N,
        S_KN2,
        S_WGT,
        S_MAC,
        S_DSTART,
        S_DIV,
        S_EMIT,
        S_SHIFT
    } cbt_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

[rtl/cubic_bspline_tessellator_top.sv]
// Top level of the uniform cubic B-spline tessellator: window, sequencer, shared multiplier.
// Depends on cbt_pkg, cbt_div and assert_macros.svh.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  new_curve, in_x, in_y, in_z
//  output    out        out_valid/out_stall  out_x, out_y, out_z, last_sample
//  config    in         cfg_we               cfg_wdata (steps per segment)
//
// A point that only fills the window is simply stored. A point that closes a window
// produces n+1 samples; for each sample the sequencer forms the basis terms and the
// weights with the shared multiplier, then for each axis runs the multiply-accumulate
// steps and the bit-serial divider (one quotient bit per cycle), and ends in one output
// step. Reset clears the control state and sets steps to 16. in_stall is high while a
// segment is in progress, and a stall on the output simply holds the sequencer in its
// output step.
`include "assert_macros.svh"

module cubic_bspline_tessellator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cbt_pkg::STEP_W-1:0]        cfg_wdata,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              new_curve,
    input  logic signed [cbt_pkg::COORD_W-1:0] in_x,
    input  logic signed [cbt_pkg::COORD_W-1:0] in_y,
    input  logic signed [cbt_pkg::COORD_W-1:0] in_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cbt_pkg::COORD_W-1:0] out_x,
    output logic signed [cbt_pkg::COORD_W-1:0] out_y,
    output logic signed [cbt_pkg::COORD_W-1:0] out_z,
    output logic                              last_sample
);
    import cbt_pkg::*;

    cbt_state_t state_reg, state_next;

    logic [STEP_W-1:0]         steps_reg;
    logic [1:0]                held_reg;
    logic [1:0]                held_eff;
    logic signed [COORD_W-1:0] win_reg [0:WIN_DEPTH-1][0:2];
    logic signed [COORD_W-1:0] pt_reg [0:2];
    logic [STEP_W-1:0]         n_reg, k_reg, m;
    logic [11:0]               n2_reg, k2_reg, m2_reg;
    logic [17:0]               n3_reg, k3_reg, m3_reg, k2n_reg, kn2_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DEN_W-1:0]          w_reg [0:3];
    logic [1:0]                coord_reg;
    logic [2:0]                j_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [COORD_W-1:0] res_reg [0:2];
    logic                      out_valid_reg, last_reg;
    logic signed [COORD_W-1:0] ox_reg, oy_reg, oz_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [COORD_W-1:0] pick;
    logic signed [23:0]        k3s, k2ns, kn2s, n3s, w1s, w2s;
    logic [DEN_W-1:0]          den_calc;
    logic                      accept, emit, div_start;
    logic [DIVD_W-1:0]         dividend;
    logic [DIVS_W-1:0]         divisor;
    logic [QUO_W-1:0]          quotient;
    div_stat_t                 div_stat;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign held_eff = new_curve ? 2'd0 : held_reg;
    assign m        = n_reg - k_reg;
    assign emit     = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign div_start = (state_reg == S_DSTART);

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        pick = (j_reg[1:0] == 2'd3) ? pt_reg[coord_reg] : win_reg[j_reg[1:0]][coord_reg];
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_NSQ:   begin mul_a = MUL_A_W'(n_reg);  mul_b = MUL_B_W'(n_reg);  end
            S_NCUBE: begin mul_a = MUL_A_W'(n2_reg); mul_b = MUL_B_W'(n_reg);  end
            S_KSQ:   begin mul_a = MUL_A_W'(k_reg);  mul_b = MUL_B_W'(k_reg);  end
            S_KCUBE: begin mul_a = MUL_A_W'(k2_reg); mul_b = MUL_B_W'(k_reg);  end
            S_MSQ:   begin mul_a = MUL_A_W'(m);      mul_b = MUL_B_W'(m);      end
            S_MCUBE: begin mul_a = MUL_A_W'(m2_reg); mul_b = MUL_B_W'(m);      end
            S_K2N:   begin mul_a = MUL_A_W'(k2_reg); mul_b = MUL_B_W'(n_reg);  end
            S_KN2:   begin mul_a = MUL_A_W'(k_reg);  mul_b = MUL_B_W'(n2_reg); end
            S_MAC:
            begin
                mul_a = {1'b0, w_reg[j_reg[1:0]]};
                mul_b = {pick[COORD_W-1], pick};
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Basis weights scaled by 6*n^3; every weight is non-negative and below 2^21.
    always_comb
    begin
        k3s  = {6'b0, k3_reg};
        k2ns = {6'b0, k2n_reg};
        kn2s = {6'b0, kn2_reg};
        n3s  = {6'b0, n3_reg};
        w1s  = (k3s + (k3s <<< 1)) - ((k2ns <<< 2) + (k2ns <<< 1)) + (n3s <<< 2);
        w2s  = n3s - (k3s + (k3s <<< 1)) + (k2ns + (k2ns <<< 1)) + (kn2s + (kn2s <<< 1));
        den_calc = DEN_W'({n3_reg, 2'b0}) + DEN_W'({n3_reg, 1'b0});
    end

    // The accumulator carries an offset of 32768*den so that it never goes negative,
    // which turns the signed rounding into an unsigned floor division.
    assign dividend = {acc_reg[DIVD_W-2:0], 1'b0} + DIVD_W'(den_reg);
    assign divisor  = {den_reg, 1'b0};

    cbt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            steps_reg     <= STEPS_RESET;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            coord_reg     <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                steps_reg <= cfg_wdata;
            end
            if (accept)
            begin
                held_reg <= (held_eff == WIN_FULL) ? WIN_FULL : held_eff + 2'd1;
                k_reg    <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                k_reg         <= k_reg + 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_WGT)
            begin
                coord_reg <= '0;
                j_reg     <= '0;
            end
            else if (state_reg == S_MAC)
            begin
                j_reg <= j_reg + 1'b1;
            end
            else if (state_reg == S_DIV && div_stat.done)
            begin
                coord_reg <= coord_reg + 1'b1;
                j_reg     <= '0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (held_eff != WIN_FULL)
            begin
                win_reg[held_eff][0] <= in_x;
                win_reg[held_eff][1] <= in_y;
                win_reg[held_eff][2] <= in_z;
            end
            pt_reg[0] <= in_x;
            pt_reg[1] <= in_y;
            pt_reg[2] <= in_z;
            n_reg     <= (steps_reg == '0) ? STEP_W'(1) : steps_reg;
        end
        unique case (state_reg)
            S_NSQ:   n2_reg  <= mul_p[11:0];
            S_NCUBE: n3_reg  <= mul_p[17:0];
            S_KSQ:   k2_reg  <= mul_p[11:0];
            S_KCUBE: k3_reg  <= mul_p[17:0];
            S_MSQ:   m2_reg  <= mul_p[11:0];
            S_MCUBE: m3_reg  <= mul_p[17:0];
            S_K2N:   k2n_reg <= mul_p[17:0];
            S_KN2:   kn2_reg <= mul_p[17:0];
            S_WGT:
            begin
                w_reg[0] <= DEN_W'(m3_reg);
                w_reg[1] <= w1s[DEN_W-1:0];
                w_reg[2] <= w2s[DEN_W-1:0];
                w_reg[3] <= DEN_W'(k3_reg);
                den_reg  <= den_calc;
            end
            S_MAC:
            begin
                prod_reg <= mul_p;
                if (j_reg == 3'd0)
                begin
                    acc_reg <= {4'b0, den_reg, 15'b0};
                end
                else
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    res_reg[coord_reg] <= {~quotient[QUO_W-1], quotient[QUO_W-2:0]};
                end
            end
            S_SHIFT:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[0][c] <= win_reg[1][c];
                    win_reg[1][c] <= win_reg[2][c];
                    win_reg[2][c] <= pt_reg[c];
                end
            end
            default: ;
        endcase
        if (emit)
        begin
            ox_reg   <= res_reg[0];
            oy_reg   <= res_reg[1];
            oz_reg   <= res_reg[2];
            last_reg <= (k_reg == n_reg);
        end
    end

    // Sequencer: basis terms, weights, per axis MAC and divide, then output and shift.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && held_eff == WIN_FULL)
                begin
                    state_next = S_NSQ;
                end
            end
            S_NSQ:    state_next = S_NCUBE;
            S_NCUBE:  state_next = S_KSQ;
            S_KSQ:    state_next = S_KCUBE;
            S_KCUBE:  state_next = S_MSQ;
            S_MSQ:    state_next = S_MCUBE;
            S_MCUBE:  state_next = S_K2N;
            S_K2N:    state_next = S_KN2;
            S_KN2:    state_next = S_WGT;
            S_WGT:    state_next = S_MAC;
            S_MAC:
            begin
                if (j_reg == 3'd4)
                begin
                    state_next = S_DSTART;
                end
            end
            S_DSTART: state_next = S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = (coord_reg == 2'd2) ? S_EMIT : S_MAC;
                end
            end
            S_EMIT:
            begin
                if (emit)
                begin
                    state_next = (k_reg == n_reg) ? S_SHIFT : S_KSQ;
                end
            end
            S_SHIFT:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign last_sample = last_reg;

    `ASSERT_CLK(a_seg_busy, (accept && held_eff == WIN_FULL) |=> in_stall, "segment not started")
    `ASSERT_CLK(a_last_ends, (out_valid && last_sample && !out_stall) |=> !out_valid, "beat after last")
    `ASSERT_CLK(a_div_idle_state, div_stat.busy |-> (state_reg == S_DIV), "divider outside divide step")

endmodule

[rtl/cbt_div.sv]
// Restoring divider, one quotient bit per cycle, for the rounded sample quotient.
// Depends on cbt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [cbt_pkg::DIVD_W-1:0]   dividend,
    input  logic [cbt_pkg::DIVS_W-1:0]   divisor,
    output logic [cbt_pkg::QUO_W-1:0]    quotient,
    output cbt_pkg::div_stat_t           stat
);
    import cbt_pkg::*;

    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dvs_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              ge;

    assign ge = (rem_reg >= dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // The divisor is aligned under the top quotient bit and walks right.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            dvs_reg <= {divisor, {(DIVD_W-DIVS_W){1'b0}}} >> 2;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            dvs_reg <= dvs_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `ASSERT_CLK(a_done_follows_busy, done_reg |-> $past(busy_reg), "divider done without work")
    `ASSERT_NEVER(a_no_restart, busy_reg && start, "divider restarted while busy")
    `ASSERT_NEVER(a_busy_done, busy_reg && done_reg, "divider busy and done together")

endmodule

[bench/cubic_bspline_tessellator_top_tb.sv]
// Self-checking bench for cubic_bspline_tessellator_top: drives control points, predicts
// every B-spline sample in-bench and checks each output beat. Depends on cbt_pkg and the RTL.
`timescale 1ns / 100ps

module cubic_bspline_tessellator_top_tb;

    import cbt_pkg::*;

    // The watchdog gives up after this many cycles with no beat on either channel.
    // Each sample and the idle pause of SETTLE_CYCLES before a register write are far
    // shorter, so this limit is many times the slowest correct quiet stretch.
    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      last;
    } sample_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [STEP_W-1:0]          cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       new_curve = 1'b0;
    logic signed [COORD_W-1:0]  in_x = '0;
    logic signed [COORD_W-1:0]  in_y = '0;
    logic signed [COORD_W-1:0]  in_z = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b1;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;
    logic                       last_sample;

    // Bench copy of the block state: register, point window and fill count.
    logic [STEP_W-1:0] steps_reg;
    longint            window_pts [3][3];
    int                points_held;

    sample_t pending_samples [$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    bit      no_gaps;      // when set, neither side inserts wait cycles

    cubic_bspline_tessellator_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .new_curve   (new_curve),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .last_sample (last_sample)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Divides num by den (den > 0), rounds to nearest with ties upward, and clamps
    // the result into the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] round_saturate(longint num, longint den);
        longint a;
        longint d;
        longint q;
        longint hi;
        a  = 2 * num + den;
        d  = 2 * den;
        q  = a / d;
        hi = (longint'(1) << (COORD_W - 1)) - 1;
        if (q * d > a)
            q = q - 1;
        if (q > hi)
            q = hi;
        if (q < -hi - 1)
            q = -hi - 1;
        return q[COORD_W-1:0];
    endfunction

    // Takes one accepted control point into the bench window. When the window already
    // holds three points, the segment is sampled at u = k/n for k = 0..n and every
    // sample is queued in order, with the final one flagged.
    task automatic predict_segment(input logic nc, input longint px, input longint py,
                                   input longint pz);
        longint p [3];
        longint n;
        longint m;
        longint den;
        longint w [4];
        longint axis [3];
        sample_t s;
        p[0] = px;
        p[1] = py;
        p[2] = pz;
        if (nc)
            points_held = 0;
        if (points_held < 3)
        begin
            window_pts[points_held] = p;
            points_held++;
            return;
        end
        // A register value of zero behaves as one interval.
        n   = (steps_reg == 0) ? 1 : longint'(steps_reg);
        den = 6 * n * n * n;
        for (longint k = 0; k <= n; k++)
        begin
            m    = n - k;
            w[0] = m * m * m;
            w[1] = 3 * k * k * k - 6 * k * k * n + 4 * n * n * n;
            w[2] = -3 * k * k * k + 3 * k * k * n + 3 * k * n * n + n * n * n;
            w[3] = k * k * k;
            for (int c = 0; c < 3; c++)
                axis[c] = w[0] * window_pts[0][c] + w[1] * window_pts[1][c]
                        + w[2] * window_pts[2][c] + w[3] * p[c];
            s.x    = round_saturate(axis[0], den);
            s.y    = round_saturate(axis[1], den);
            s.z    = round_saturate(axis[2], den);
            s.last = (k == n);
            pending_samples = {pending_samples, s};
        end
        window_pts[0] = window_pts[1];
        window_pts[1] = window_pts[2];
        window_pts[2] = p;
    endtask

    // Presents one control point after a random gap and holds it until the block takes
    // it. Valid stays high on return, so a following beat with no gap keeps it high
    // instead of lowering and raising it in the same step.
    task automatic send_point(input logic nc, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        new_curve <= nc;
        in_x      <= x;
        in_y      <= y;
        in_z      <= z;
        do
            @(posedge clk);
        while (in_stall);
        predict_segment(nc, longint'($signed(x)), longint'($signed(y)),
                        longint'($signed(z)));
    endtask

    // Lowers valid, lets every expected sample drain, and then waits out any work that
    // produces no sample, so the block is idle afterwards.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the steps register; only called while the block is idle.
    task automatic write_steps(input logic [STEP_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        steps_reg = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_point(input int restart_odds);
        send_point(($urandom_range(0, restart_odds - 1) == 0), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // The reset value of 16 intervals, the coordinate extremes and exact ties.
    task automatic test_reset_steps;
        send_point(1'b0, 16'sh8000, 16'sh7FFF, 16'sh0000);
        send_point(1'b0, 16'sh7FFF, 16'sh8000, 16'shFFFF);
        send_point(1'b0, 16'sh8000, 16'sh7FFF, 16'sh0001);
        send_point(1'b0, 16'sh7FFF, 16'sh8000, 16'shFFFF);
        send_point(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_point(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
    endtask

    // A zero register acts as one interval; 1 and 63 are the range ends.
    task automatic test_step_extremes;
        write_steps('0);
        send_point(1'b0, 16'sh0001, 16'shFFFF, 16'sh0003);
        send_point(1'b0, 16'sh0000, 16'sh0005, 16'shFFFD);
        write_steps(6'd1);
        send_point(1'b0, 16'sh1234, 16'shEDCB, 16'sh0100);
        write_steps(6'd63);
        send_point(1'b0, 16'sh7FFF, 16'sh8000, 16'sh5555);
        send_point(1'b0, 16'shAAAA, 16'sh0000, 16'sh8000);
    endtask

    // A restart empties the window: three points give nothing, the fourth a segment.
    task automatic test_new_curve;
        write_steps(6'd3);
        send_point(1'b1, 16'sh0100, 16'sh0200, 16'sh0300);
        send_point(1'b0, 16'shFF00, 16'sh0000, 16'sh0100);
        send_point(1'b0, 16'sh0400, 16'shFC00, 16'sh0000);
        send_point(1'b0, 16'sh0000, 16'sh0100, 16'shFF00);
        send_point(1'b1, 16'sh0700, 16'sh0700, 16'sh0700);
        send_point(1'b1, 16'sh0100, 16'sh0100, 16'sh0100);
        send_point(1'b0, 16'sh0200, 16'sh0200, 16'sh0200);
        send_point(1'b0, 16'sh0300, 16'sh0300, 16'sh0300);
        send_point(1'b0, 16'sh0400, 16'sh0400, 16'sh0400);
    endtask

    // Random points in phases of fresh register settings. Mostly small step counts keep
    // the run short; one phase runs back to back with no gaps on either side.
    task automatic test_random_points;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_steps(STEP_W'($urandom_range(1, 8)));
            no_gaps = (phase == 2);
            for (int i = 0; i < 30; i++)
                send_random_point(12);
        end
        no_gaps = 1'b0;
        write_steps(STEP_W'($urandom_range(9, 62)));
        for (int i = 0; i < 4; i++)
            send_random_point(8);
    endtask

    // Output side: stalls a random number of cycles before each beat, then checks the
    // beat against the oldest expected sample.
    initial
    begin
        int      wait_cycles;
        sample_t want;
        forever
        begin
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rst_n && out_valid));
            if (pending_samples.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected sample beat: x=%0d y=%0d z=%0d last=%0b",
                             out_x, out_y, out_z, last_sample);
            end
            else
            begin
                want = pending_samples.pop_front();
                if (out_x !== want.x || out_y !== want.y || out_z !== want.z
                    || last_sample !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("sample mismatch: expected x=%0d y=%0d z=%0d last=%0b,",
                                 want.x, want.y, want.z, want.last,
                                 " got x=%0d y=%0d z=%0d last=%0b",
                                 out_x, out_y, out_z, last_sample);
                end
            end
        end
    end

    // Watchdog: a run that stops moving beats on both channels is a failure.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("cubic_bspline_tessellator_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        steps_reg      = STEPS_RESET;
        points_held    = 0;
        no_gaps        = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_steps();
        test_step_extremes();
        test_new_curve();
        test_random_points();

        drain();
        if (mismatch_count == 0 && pending_samples.size() == 0)
            $display("cubic_bspline_tessellator_top regression: pass");
        else
            $display("cubic_bspline_tessellator_top regression: fail");
        $finish;
    end

endmodule
